[design/lgs_pkg.sv]
// Shared types and constants of the toroidal life generation step unit.
// No dependencies; imported by lgs_row_update, life_generation_step_unit and the testbench.

package lgs_pkg;

   localparam int MAX_SIZE_DEF = 64;
   localparam int MIN_SIZE     = 3;

   localparam int CSR_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_HEIGHT = 1'b1;
   localparam logic [CSR_W-1:0]     SIZE_RESET      = 7'd64;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 8;

   typedef enum logic [1:0] {
      MODE_WRITE   = 2'd0,
      MODE_READ    = 2'd1,
      MODE_ADVANCE = 2'd2,
      MODE_NOP     = 2'd3
   } mode_type;

   typedef logic [3:0] count_type;
   localparam count_type COUNT_KEEP  = 4'd2;
   localparam count_type COUNT_BIRTH = 4'd3;

endpackage

[design/lgs_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.

module lgs_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/lgs_row_update.sv]
// Next-generation kernel for one grid row, wrapping at the active width.
// Depends on lgs_pkg; used by life_generation_step_unit.

module lgs_row_update
   import lgs_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic [MAX_SIZE-1:0]            north,
   input  logic [MAX_SIZE-1:0]            center,
   input  logic [MAX_SIZE-1:0]            south,
   input  logic [$clog2(MAX_SIZE+1)-1:0]  width,
   output logic [MAX_SIZE-1:0]            next_row
);

   localparam int SW  = $clog2(MAX_SIZE + 1);
   localparam int CIW = $clog2(MAX_SIZE);

   logic [SW-1:0]  last_col;
   logic [CIW-1:0] last_idx;
   logic           n_wrap_w;
   logic           c_wrap_w;
   logic           s_wrap_w;

   assign last_col = width - SW'(1);
   assign last_idx = CIW'(last_col);
   assign n_wrap_w = north[last_idx];
   assign c_wrap_w = center[last_idx];
   assign s_wrap_w = south[last_idx];

   for (genvar c = 0; c < MAX_SIZE; c++) begin : g_col
      logic      nw, cw, sw, ne, ce, se;
      count_type cnt;

      if (c == 0) begin : g_west_wrap
         assign nw = n_wrap_w;
         assign cw = c_wrap_w;
         assign sw = s_wrap_w;
      end else begin : g_west
         assign nw = north[c-1];
         assign cw = center[c-1];
         assign sw = south[c-1];
      end

      if (c == MAX_SIZE - 1) begin : g_east_wrap
         assign ne = north[0];
         assign ce = center[0];
         assign se = south[0];
      end else begin : g_east
         logic at_last;

         assign at_last = (SW'(c) == last_col);
         assign ne = at_last ? north[0]  : north[c+1];
         assign ce = at_last ? center[0] : center[c+1];
         assign se = at_last ? south[0]  : south[c+1];
      end

      assign cnt = count_type'($countones({nw, north[c], ne, cw, ce, sw, south[c], se}));

      always_comb begin
         if (SW'(c) < width) begin
            next_row[c] = (cnt == COUNT_BIRTH) || (center[c] && (cnt == COUNT_KEEP));
         end else begin
            next_row[c] = center[c];
         end
      end
   end

endmodule

[design/life_generation_step_unit.sv]
// Top level of the toroidal life generation step unit: item handshake,
// sequencer and grid memory. Depends on lgs_pkg, lgs_ram and lgs_row_update.
//
// The grid lives in one row-wide memory, one word per row, with a valid bit
// per row so that reset shows an all-dead grid at once (no clearing pass).
// One item is worked at a time. A cell write reads the row, merges the cell,
// writes the row back and then gives the result. In an advance the
// sequencer streams one row per cycle through the single read and single
// write port of the grid memory, updating rows in place while the first
// row's old value is held aside for the wrap. A new item is taken while
// the previous result still waits in the output register.

module life_generation_step_unit
   import lgs_pkg::*;
#(
   parameter int MAX_SIZE = MAX_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // mode[1:0], row[7:2], col[13:8], alive[14]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // cell_alive[0]
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wr_data
);

   localparam int SW  = $clog2(MAX_SIZE + 1);
   localparam int CIW = $clog2(MAX_SIZE);
   localparam int CW  = (SW > CSR_W) ? SW + 1 : CSR_W + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CELL_WR,
      ST_CELL_RD,
      ST_ADV_A,
      ST_ADV_B,
      ST_ADV_RUN,
      ST_RESP
   } state_type;

   state_type            state_ff;
   logic [CSR_W-1:0]     width_ff;
   logic [CSR_W-1:0]     height_ff;
   logic [MAX_SIZE-1:0]  valid_ff;
   logic                 rvalid_ff;
   logic [CIW-1:0]       row_ff;
   logic [CIW-1:0]       col_ff;
   logic                 alive_ff;
   logic                 inside_ff;
   logic                 res_ff;
   logic [CIW-1:0]       row_cnt_ff;
   logic [MAX_SIZE-1:0]  north_ff;
   logic [MAX_SIZE-1:0]  center_ff;
   logic [MAX_SIZE-1:0]  row0_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_data_ff;

   logic                 req_acc;
   mode_type             f_mode;
   logic [5:0]           f_row;
   logic [5:0]           f_col;
   logic                 f_alive;
   logic [SW-1:0]        w_eff;
   logic [SW-1:0]        h_eff;
   logic [SW-1:0]        h_last;
   logic                 f_inside;
   logic                 last_row;
   logic                 rsp_free;

   logic                 ram_we;
   logic [CIW-1:0]       ram_waddr;
   logic [MAX_SIZE-1:0]  ram_wdata;
   logic [CIW-1:0]       ram_raddr;
   logic [MAX_SIZE-1:0]  ram_rdata;
   logic [MAX_SIZE-1:0]  row_data;
   logic [MAX_SIZE-1:0]  merged;
   logic [MAX_SIZE-1:0]  south;
   logic [MAX_SIZE-1:0]  new_row;

   function automatic logic [SW-1:0] clamp_size(input logic [CSR_W-1:0] v);
      logic [CW-1:0] ext;
      ext = CW'(v);
      if (ext < CW'(MIN_SIZE)) begin
         return SW'(MIN_SIZE);
      end else if (ext > CW'(MAX_SIZE)) begin
         return SW'(MAX_SIZE);
      end
      return SW'(ext);
   endfunction

   assign w_eff  = clamp_size(width_ff);
   assign h_eff  = clamp_size(height_ff);
   assign h_last = h_eff - SW'(1);

   assign req_tready = (state_ff == ST_IDLE) && !reset;
   assign req_acc    = req_tvalid && req_tready;
   assign f_mode     = mode_type'(req_tdata[1:0]);
   assign f_row      = req_tdata[7:2];
   assign f_col      = req_tdata[13:8];
   assign f_alive    = req_tdata[14];
   assign f_inside   = (CW'(f_row) < CW'(h_eff)) && (CW'(f_col) < CW'(w_eff));

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   assign row_data = rvalid_ff ? ram_rdata : '0;
   assign last_row = (SW'(row_cnt_ff) == h_last);
   assign south    = last_row ? row0_ff : row_data;

   always_comb begin
      merged         = row_data;
      merged[col_ff] = alive_ff;
   end

   always_comb begin
      ram_raddr = row_ff;
      ram_we    = 1'b0;
      ram_waddr = row_ff;
      ram_wdata = merged;
      case (state_ff)
         ST_IDLE: begin
            if (f_mode == MODE_ADVANCE) begin
               ram_raddr = CIW'(h_last);
            end else begin
               ram_raddr = CIW'(f_row);
            end
         end
         ST_CELL_WR: begin
            ram_we = inside_ff;
         end
         ST_ADV_A: begin
            ram_raddr = '0;
         end
         ST_ADV_B: begin
            ram_raddr = CIW'(1);
         end
         ST_ADV_RUN: begin
            ram_raddr = row_cnt_ff + CIW'(2);
            ram_we    = 1'b1;
            ram_waddr = row_cnt_ff;
            ram_wdata = new_row;
         end
         default: begin
         end
      endcase
   end

   lgs_ram #(
      .WIDTH (MAX_SIZE),
      .DEPTH (MAX_SIZE)
   ) u_grid (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   lgs_row_update #(
      .MAX_SIZE (MAX_SIZE)
   ) u_row (
      .north    (north_ff),
      .center   (center_ff),
      .south    (south),
      .width    (w_eff),
      .next_row (new_row)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= SIZE_RESET;
         height_ff    <= SIZE_RESET;
         valid_ff     <= '0;
         rvalid_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_cnt_ff   <= '0;
      end else begin
         rvalid_ff <= valid_ff[ram_raddr];
         if (ram_we) begin
            valid_ff[ram_waddr] <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_GRID_WIDTH:  width_ff  <= csr_wr_data;
               CSR_GRID_HEIGHT: height_ff <= csr_wr_data;
               default: begin
               end
            endcase
         end
         if (rsp_valid_ff && rsp_tready && (state_ff != ST_RESP)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_acc) begin
                  row_ff    <= CIW'(f_row);
                  col_ff    <= CIW'(f_col);
                  alive_ff  <= f_alive;
                  inside_ff <= f_inside;
                  res_ff    <= 1'b0;
                  case (f_mode)
                     MODE_WRITE:   state_ff <= ST_CELL_WR;
                     MODE_READ:    state_ff <= ST_CELL_RD;
                     MODE_ADVANCE: state_ff <= ST_ADV_A;
                     default:      state_ff <= ST_RESP;
                  endcase
               end
            end
            ST_CELL_WR: begin
               state_ff <= ST_RESP;
            end
            ST_CELL_RD: begin
               res_ff   <= inside_ff && row_data[col_ff];
               state_ff <= ST_RESP;
            end
            ST_ADV_A: begin
               north_ff <= row_data;
               state_ff <= ST_ADV_B;
            end
            ST_ADV_B: begin
               center_ff  <= row_data;
               row0_ff    <= row_data;
               row_cnt_ff <= '0;
               state_ff   <= ST_ADV_RUN;
            end
            ST_ADV_RUN: begin
               north_ff   <= center_ff;
               center_ff  <= south;
               row_cnt_ff <= row_cnt_ff + CIW'(1);
               if (last_row) begin
                  state_ff <= ST_RESP;
               end
            end
            ST_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   a_row_in_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_RUN) |-> (SW'(row_cnt_ff) < h_eff))
      else $error("advance row counter beyond active height");

   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADV_RUN) |-> (ram_waddr != ram_raddr))
      else $error("advance writes the row it reads");

   a_resp_handoff: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && rsp_free) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("result not handed to the output register");

   a_write_result_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CELL_WR) |=> !res_ff)
      else $error("write item carries a nonzero result");

endmodule

[tb/life_generation_step_unit_tb.sv]
// Self-checking testbench for life_generation_step_unit: cell writes, reads and
// generation steps on a wrapped grid, checked item by item against a local model.
// Depends on lgs_pkg and the life_generation_step_unit RTL.
`timescale 1ns / 1ps

module life_generation_step_unit_tb;
   import lgs_pkg::*;

   localparam int GRID_MAX    = 64;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD   = 400;

   class life_scoreboard;
      bit [GRID_MAX-1:0] cells [GRID_MAX];
      bit [CSR_W-1:0]    width_reg;
      bit [CSR_W-1:0]    height_reg;
      bit                cell_q [$];
      int                errors;
      int                n_writes, n_reads, n_live_reads, n_advances, n_nops;

      function new();
         foreach (cells[r]) cells[r] = '0;
         width_reg  = SIZE_RESET;
         height_reg = SIZE_RESET;
      endfunction

      function int eff_size(bit [CSR_W-1:0] v);
         if (v < MIN_SIZE) return MIN_SIZE;
         if (v > GRID_MAX) return GRID_MAX;
         return int'(v);
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] idx, bit [CSR_W-1:0] v);
         if (idx == CSR_GRID_WIDTH) width_reg = v;
         else height_reg = v;
      endfunction

      function int pending();
         return cell_q.size();
      endfunction

      function void advance_generation();
         bit [GRID_MAX-1:0] prev [GRID_MAX];
         int w, h, rn, rs, cw, ce, n;
         w = eff_size(width_reg);
         h = eff_size(height_reg);
         prev = cells;
         for (int r = 0; r < h; r++) begin
            rn = (r + h - 1) % h;
            rs = (r + 1) % h;
            for (int c = 0; c < w; c++) begin
               cw = (c + w - 1) % w;
               ce = (c + 1) % w;
               n = int'(prev[rn][cw]) + int'(prev[rn][c]) + int'(prev[rn][ce])
                 + int'(prev[r][cw]) + int'(prev[r][ce])
                 + int'(prev[rs][cw]) + int'(prev[rs][c]) + int'(prev[rs][ce]);
               cells[r][c] = (prev[r][c] && n == COUNT_KEEP) || n == COUNT_BIRTH;
            end
         end
      endfunction

      function void note_item(mode_type m, bit [5:0] row, bit [5:0] col, bit alive);
         bit in_window;
         bit cell_val;
         in_window = row < eff_size(height_reg) && col < eff_size(width_reg);
         cell_val = 1'b0;
         case (m)
            MODE_WRITE: begin
               n_writes++;
               if (in_window) cells[row][col] = alive;
            end
            MODE_READ: begin
               n_reads++;
               if (in_window) cell_val = cells[row][col];
               if (cell_val) n_live_reads++;
            end
            MODE_ADVANCE: begin
               n_advances++;
               advance_generation();
            end
            default: n_nops++;
         endcase
         cell_q.push_back(cell_val);
      endfunction

      function void check_result(bit got);
         bit want;
         if (cell_q.size() == 0) begin
            $error("cell_alive: result with no item waiting, expected none, actual %0d", got);
            errors++;
            return;
         end
         want = cell_q.pop_front();
         if (got !== want) begin
            $error("cell_alive mismatch: expected %0d, actual %0d", want, got);
            errors++;
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // mode[1:0], row[7:2], col[13:8], alive[14]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;          // cell_alive[0]
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_W-1:0]      csr_wr_data = '0;

   life_scoreboard board = new();
   int  burst_left = 1;
   int  n_settings = 0;
   bit  hold_off_req = 1'b0;
   int  cycle_count = 0;

   life_generation_step_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("life_generation_step_unit_tb failed");
      $finish;
   end

   // result side: checks items and stalls on its own pattern
   initial begin
      int style, seg_left, hold_left;
      bit ready_next;
      style = 0;
      seg_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid === 1'b1 && rsp_tready === 1'b1) board.check_result(rsp_tdata[0]);
         if (hold_off_req) begin
            hold_left = LONG_HOLD;
            hold_off_req = 1'b0;
         end
         if (seg_left == 0) begin
            style = $urandom_range(0, 3);
            seg_left = $urandom_range(20, 200);
         end
         seg_left--;
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else begin
            case (style)
               0: ready_next = 1'b1;
               1: ready_next = $urandom_range(0, 1);
               2: ready_next = $urandom_range(0, 99) < 85;
               default: ready_next = $urandom_range(0, 99) < 20;
            endcase
         end
         rsp_tready <= reset ? 1'b0 : ready_next;
      end
   end

   task automatic send_item(input mode_type m, input logic [5:0] row, input logic [5:0] col,
                            input logic alive);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, alive, col, row, m};
      do @(posedge clock); while (req_tready !== 1'b1);
      board.note_item(m, row, col, alive);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // wait until every expected result is in, then let the block settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_size(input logic [CSR_W-1:0] w, input logic [CSR_W-1:0] h);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_GRID_WIDTH;
      csr_wr_data <= w;
      @(posedge clock);
      board.set_register(CSR_GRID_WIDTH, w);
      csr_index   <= CSR_GRID_HEIGHT;
      csr_wr_data <= h;
      @(posedge clock);
      board.set_register(CSR_GRID_HEIGHT, h);
      csr_wr_en <= 1'b0;
      n_settings++;
   endtask

   task automatic run_directed();
      // corners wrap into one still block
      send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
      send_item(MODE_READ, 6'd63, 6'd63, 1'b1);
      send_item(MODE_WRITE, 6'd0, 6'd0, 1'b1);
      send_item(MODE_WRITE, 6'd63, 6'd63, 1'b1);
      send_item(MODE_WRITE, 6'd0, 6'd63, 1'b1);
      send_item(MODE_WRITE, 6'd63, 6'd0, 1'b1);
      send_item(MODE_NOP, 6'd63, 6'd63, 1'b1);
      // blinker
      send_item(MODE_WRITE, 6'd40, 6'd39, 1'b1);
      send_item(MODE_WRITE, 6'd40, 6'd40, 1'b1);
      send_item(MODE_WRITE, 6'd40, 6'd41, 1'b1);
      send_item(MODE_ADVANCE, 6'd0, 6'd0, 1'b0);
      send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
      send_item(MODE_READ, 6'd63, 6'd0, 1'b0);
      send_item(MODE_READ, 6'd39, 6'd40, 1'b0);
      send_item(MODE_READ, 6'd40, 6'd39, 1'b0);
      drain();
      // small window: writes and reads outside are ignored, far cells stay
      set_size(7'd5, 7'd6);
      send_item(MODE_WRITE, 6'd6, 6'd2, 1'b1);
      send_item(MODE_WRITE, 6'd2, 6'd5, 1'b1);
      send_item(MODE_READ, 6'd2, 6'd5, 1'b0);
      send_item(MODE_WRITE, 6'd1, 6'd4, 1'b1);
      send_item(MODE_ADVANCE, 6'd63, 6'd63, 1'b1);
      send_item(MODE_READ, 6'd0, 6'd4, 1'b0);
      drain();
      set_size(7'd64, 7'd64);
      send_item(MODE_READ, 6'd41, 6'd40, 1'b0);
      send_item(MODE_READ, 6'd63, 6'd63, 1'b0);
      drain();
   endtask

   task automatic run_random_phase(input int count, input bit long_hold);
      int w, h, fill, seed_n, pick;
      logic [5:0] row, col;
      w = board.eff_size(board.width_reg);
      h = board.eff_size(board.height_reg);
      fill = $urandom_range(15, 55);
      seed_n = $urandom_range(5, 40);
      for (int i = 0; i < count; i++) begin
         if (long_hold && i == count / 3) hold_off_req = 1'b1;
         row = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, h - 1));
         col = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, w - 1));
         pick = (i < seed_n) ? 0 : $urandom_range(0, 99);
         if (pick < 40)
            send_item(MODE_WRITE, row, col, $urandom_range(0, 99) < fill);
         else if (pick < 78)
            send_item(MODE_READ, row, col, $urandom_range(0, 1));
         else if (pick < 95)
            send_item(MODE_ADVANCE, row, col, $urandom_range(0, 1));
         else
            send_item(MODE_NOP, row, col, $urandom_range(0, 1));
      end
   endtask

   initial begin
      logic [CSR_W-1:0] widths  [10];
      logic [CSR_W-1:0] heights [10];
      widths  = '{7'd3, 7'd0, 7'd127, 7'd5, 7'd17, 7'd64, 7'd3, 7'd30, 7'd65, 7'd64};
      heights = '{7'd3, 7'd1, 7'd100, 7'd7, 7'd9, 7'd3, 7'd64, 7'd41, 7'd2, 7'd64};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      for (int p = 0; p < 12; p++) begin
         if (p < 10) set_size(widths[p], heights[p]);
         else set_size(7'($urandom_range(3, 64)), 7'($urandom_range(3, 64)));
         run_random_phase(130, p == 3 || p == 9);
         drain();
      end
      repeat (80) @(posedge clock);
      $display("covered %0d writes, %0d reads (%0d live), %0d generation steps, %0d unused-mode items",
               board.n_writes, board.n_reads, board.n_live_reads, board.n_advances, board.n_nops);
      $display("over %0d grid size settings, including clamped and wrapped extremes", n_settings);
      if (board.errors == 0 && board.pending() == 0)
         $display("life_generation_step_unit_tb passed");
      else
         $display("life_generation_step_unit_tb failed");
      $finish;
   end

endmodule

[files.f]
design/lgs_pkg.sv
design/lgs_ram.sv
design/lgs_row_update.sv
design/life_generation_step_unit.sv
tb/life_generation_step_unit_tb.sv
